@@ rtl/core/pic_pkg.sv @@
`timescale 1ns / 1ps
// Point-in-cone test: shared widths, payload structs, register codes and
// the radius saturation helper. No dependencies.
package pic_pkg;

    localparam int COORD_W   = 24;
    localparam int UNIT_FRAC = 14;
    localparam int UNIT_W    = UNIT_FRAC + 2;
    localparam int SIN_W     = UNIT_FRAC + 1;
    localparam int HEIGHT_W  = COORD_W - 1;

    localparam int CFG_IDX_W = 3;

    localparam int DIFF_W   = COORD_W + 1;             // point - apex
    localparam int HPROD_W  = UNIT_W + DIFF_W;         // axis * v
    localparam int HFULL_W  = HPROD_W + 2;             // axis . v
    localparam int SQ_W     = 2 * DIFF_W - 1;          // v component squared
    localparam int LHS_W    = SQ_W + 2;                // |v|^2
    localparam int FPROD_W  = 2 * UNIT_W;              // axis * normal
    localparam int FACE_W   = FPROD_W + 3;             // -(axis . normal)
    localparam int COSS_W   = UNIT_W + UNIT_FRAC;      // cos_open scaled
    localparam int HLIM_W   = HEIGHT_W + UNIT_FRAC;    // height scaled
    localparam int RADP_W   = HEIGHT_W + SIN_W;        // length * sine
    localparam int HSQ_W    = 2 * HEIGHT_W;            // h squared
    localparam int T_W      = COORD_W + 1;             // radius + margin
    localparam int TSQ_W    = 2 * T_W - 1;
    localparam int RHS_W    = TSQ_W + 1;

    localparam logic [HEIGHT_W-1:0] RADIUS_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_APEX_X,
        CFG_APEX_Y,
        CFG_APEX_Z,
        CFG_AXIS_X,
        CFG_AXIS_Y,
        CFG_AXIS_Z,
        CFG_CONE_HEIGHT,
        CFG_SIN_HALF_ANGLE
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] margin;
        logic                      check_face;
        logic signed [UNIT_W-1:0]  normal_x;
        logic signed [UNIT_W-1:0]  normal_y;
        logic signed [UNIT_W-1:0]  normal_z;
        logic signed [UNIT_W-1:0]  cos_open;
    } t_pic_req;

    typedef struct packed {
        logic                inside_res;
        logic [HEIGHT_W-1:0] base_radius;
    } t_pic_res;

    typedef struct packed {
        logic signed [COORD_W-1:0] apex_x;
        logic signed [COORD_W-1:0] apex_y;
        logic signed [COORD_W-1:0] apex_z;
        logic signed [UNIT_W-1:0]  axis_x;
        logic signed [UNIT_W-1:0]  axis_y;
        logic signed [UNIT_W-1:0]  axis_z;
        logic [HEIGHT_W-1:0]       cone_height;
        logic [SIN_W-1:0]          sin_half_angle;
    } t_pic_cfg;

    // Front half of the pipe to the back half
    typedef struct packed {
        logic signed [HFULL_W-1:0] h_full;
        logic [LHS_W-1:0]          lhs;
        logic signed [COORD_W-1:0] margin;
        logic                      check_face;
        logic signed [FACE_W-1:0]  facing;
        logic signed [UNIT_W-1:0]  cos_open;
    } t_pic_mid;

    // floor(prod / 2^UNIT_FRAC), clipped to the largest radius
    function automatic logic [HEIGHT_W-1:0] sat_radius(input logic [RADP_W-1:0] prod);
        logic [HEIGHT_W:0] q;
        q = prod[RADP_W-1:UNIT_FRAC];
        sat_radius = q[HEIGHT_W] ? RADIUS_MAX : q[HEIGHT_W-1:0];
    endfunction

endpackage

@@ rtl/core/pic_cfg.sv @@
`timescale 1ns / 1ps
// Cone configuration registers and the registered base radius product.
// Depends on pic_pkg.
module pic_cfg
    import pic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [COORD_W-1:0]   i_data,
    output t_pic_cfg             o_cfg,
    output logic [HEIGHT_W-1:0]  o_base_radius
);

    t_pic_cfg          r_cfg;
    t_pic_cfg          n_cfg;
    t_pic_cfg          rst_cfg;
    logic [RADP_W-1:0] r_base_prod;

    // reset cone: zero everywhere, axis along +y
    always_comb begin
        rst_cfg        = '0;
        rst_cfg.axis_y = UNIT_W'(1) <<< UNIT_FRAC;
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_cfg_idx'(i_idx))
                CFG_APEX_X:         n_cfg.apex_x = i_data;
                CFG_APEX_Y:         n_cfg.apex_y = i_data;
                CFG_APEX_Z:         n_cfg.apex_z = i_data;
                CFG_AXIS_X:         n_cfg.axis_x = i_data[UNIT_W-1:0];
                CFG_AXIS_Y:         n_cfg.axis_y = i_data[UNIT_W-1:0];
                CFG_AXIS_Z:         n_cfg.axis_z = i_data[UNIT_W-1:0];
                CFG_CONE_HEIGHT:    n_cfg.cone_height = i_data[HEIGHT_W-1:0];
                CFG_SIN_HALF_ANGLE: n_cfg.sin_half_angle = i_data[SIN_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= rst_cfg;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // config must stay static while items are in flight (not enforced here), so the product's lag is fine
    always_ff @(posedge i_clk) begin
        r_base_prod <= RADP_W'(r_cfg.cone_height) * RADP_W'(r_cfg.sin_half_angle);
    end

    assign o_cfg         = r_cfg;
    assign o_base_radius = sat_radius(r_base_prod);

endmodule

@@ rtl/core/pic_front.sv @@
`timescale 1ns / 1ps
// Front pipe: offset from apex, products against axis, squares, and sums.
// Three register stages. Depends on pic_pkg.
module pic_front
    import pic_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_vld,
    input  t_pic_req i_req,
    input  t_pic_cfg i_cfg,
    output logic     o_vld,
    output t_pic_mid o_mid
);

    // stage 1: v = point - apex
    logic                     r_s1_vld;
    logic signed [DIFF_W-1:0] r_vx, r_vy, r_vz;
    t_pic_req                 r_s1_req;

    // stage 2: products
    logic                      r_s2_vld;
    logic signed [HPROD_W-1:0] r_hx, r_hy, r_hz;
    logic [SQ_W-1:0]           r_sqx, r_sqy, r_sqz;
    logic signed [FPROD_W-1:0] r_fx, r_fy, r_fz;
    logic signed [COORD_W-1:0] r_s2_margin;
    logic                      r_s2_check;
    logic signed [UNIT_W-1:0]  r_s2_cos;

    // stage 3: sums
    logic     r_s3_vld;
    t_pic_mid r_mid;
    t_pic_mid n_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vx     <= DIFF_W'(i_req.point_x) - DIFF_W'(i_cfg.apex_x);
        r_vy     <= DIFF_W'(i_req.point_y) - DIFF_W'(i_cfg.apex_y);
        r_vz     <= DIFF_W'(i_req.point_z) - DIFF_W'(i_cfg.apex_z);
        r_s1_req <= i_req;
    end

    always_ff @(posedge i_clk) begin
        r_hx        <= HPROD_W'(i_cfg.axis_x) * HPROD_W'(r_vx);
        r_hy        <= HPROD_W'(i_cfg.axis_y) * HPROD_W'(r_vy);
        r_hz        <= HPROD_W'(i_cfg.axis_z) * HPROD_W'(r_vz);
        r_sqx       <= SQ_W'(SQ_W'(r_vx) * SQ_W'(r_vx));
        r_sqy       <= SQ_W'(SQ_W'(r_vy) * SQ_W'(r_vy));
        r_sqz       <= SQ_W'(SQ_W'(r_vz) * SQ_W'(r_vz));
        r_fx        <= FPROD_W'(i_cfg.axis_x) * FPROD_W'(r_s1_req.normal_x);
        r_fy        <= FPROD_W'(i_cfg.axis_y) * FPROD_W'(r_s1_req.normal_y);
        r_fz        <= FPROD_W'(i_cfg.axis_z) * FPROD_W'(r_s1_req.normal_z);
        r_s2_margin <= r_s1_req.margin;
        r_s2_check  <= r_s1_req.check_face;
        r_s2_cos    <= r_s1_req.cos_open;
    end

    // |v| < 2^24 per component, so the squares and their sum never wrap
    always_comb begin
        n_mid.h_full     = HFULL_W'(r_hx) + HFULL_W'(r_hy) + HFULL_W'(r_hz);
        n_mid.lhs        = LHS_W'(r_sqx) + LHS_W'(r_sqy) + LHS_W'(r_sqz);
        n_mid.margin     = r_s2_margin;
        n_mid.check_face = r_s2_check;
        n_mid.facing     = -(FACE_W'(r_fx) + FACE_W'(r_fy) + FACE_W'(r_fz));
        n_mid.cos_open   = r_s2_cos;
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
    end

    assign o_vld = r_s3_vld;
    assign o_mid = r_mid;

endmodule

@@ rtl/core/pic_back.sv @@
`timescale 1ns / 1ps
// Back pipe: height range check, cone radius at h, margin, squares and the
// final compare with the facing test. Four register stages. Depends on pic_pkg.
module pic_back
    import pic_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  t_pic_mid            i_mid,
    input  t_pic_cfg            i_cfg,
    input  logic [HEIGHT_W-1:0] i_base_radius,
    output logic                o_done,
    output t_pic_res            o_res
);

    logic                r_s4_vld, r_s5_vld, r_s6_vld, r_done;

    // stage 4
    logic                      r_s4_range;
    logic                      r_s4_face_ok;
    logic [RADP_W-1:0]         r_s4_rprod;
    logic [HSQ_W-1:0]          r_s4_hsq;
    logic [LHS_W-1:0]          r_s4_lhs;
    logic signed [COORD_W-1:0] r_s4_margin;

    // stage 5
    logic                  r_s5_range, r_s5_face_ok;
    logic signed [T_W-1:0] r_s5_t;
    logic [HSQ_W-1:0]      r_s5_hsq;
    logic [LHS_W-1:0]      r_s5_lhs;

    // stage 6
    logic              r_s6_range, r_s6_face_ok;
    logic [TSQ_W-1:0]  r_s6_tsq;
    logic [HSQ_W-1:0]  r_s6_hsq;
    logic [LHS_W-1:0]  r_s6_lhs;

    t_pic_res r_res;
    t_pic_res n_res;

    logic [HLIM_W-1:0]       h_lim;
    logic                    n_range;
    logic [HEIGHT_W-1:0]     h8;
    logic signed [COSS_W-1:0] cos_scaled;
    logic                    n_face_ok;
    logic [HEIGHT_W-1:0]     radius;
    logic [RHS_W-1:0]        rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s4_vld <= i_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            r_done   <= r_s6_vld;
        end
    end

    // 0 <= h <= height, both in Q.14 before the floor to coordinate units
    always_comb begin
        h_lim      = {i_cfg.cone_height, {UNIT_FRAC{1'b0}}};
        n_range    = !i_mid.h_full[HFULL_W-1] &&
                     (i_mid.h_full[HFULL_W-2:0] <= (HFULL_W-1)'(h_lim));
        h8         = i_mid.h_full[UNIT_FRAC +: HEIGHT_W];
        cos_scaled = {i_mid.cos_open, {UNIT_FRAC{1'b0}}};
        n_face_ok  = !i_mid.check_face || (i_mid.facing > FACE_W'(cos_scaled));
    end

    always_ff @(posedge i_clk) begin
        r_s4_range   <= n_range;
        r_s4_face_ok <= n_face_ok;
        r_s4_rprod   <= RADP_W'(h8) * RADP_W'(i_cfg.sin_half_angle);
        r_s4_hsq     <= HSQ_W'(h8) * HSQ_W'(h8);
        r_s4_lhs     <= i_mid.lhs;
        r_s4_margin  <= i_mid.margin;
    end

    assign radius = sat_radius(r_s4_rprod);

    // t may go negative; it is squared regardless
    always_ff @(posedge i_clk) begin
        r_s5_range   <= r_s4_range;
        r_s5_face_ok <= r_s4_face_ok;
        r_s5_t       <= T_W'($signed({1'b0, radius})) + T_W'(r_s4_margin);
        r_s5_hsq     <= r_s4_hsq;
        r_s5_lhs     <= r_s4_lhs;
    end

    always_ff @(posedge i_clk) begin
        r_s6_range   <= r_s5_range;
        r_s6_face_ok <= r_s5_face_ok;
        r_s6_tsq     <= TSQ_W'(TSQ_W'(r_s5_t) * TSQ_W'(r_s5_t));
        r_s6_hsq     <= r_s5_hsq;
        r_s6_lhs     <= r_s5_lhs;
    end

    always_comb begin
        rhs               = RHS_W'(r_s6_tsq) + RHS_W'(r_s6_hsq);
        n_res.inside_res  = r_s6_range && r_s6_face_ok && (r_s6_lhs < LHS_W'(rhs));
        n_res.base_radius = i_base_radius;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ rtl/core/point_in_cone_test.sv @@
`timescale 1ns / 1ps
// Point-in-cone test. One request per clock; busy never rises and the result
// strobe o_done follows each taken request through the seven register stages
// of the arithmetic pipe (offset, products, sums, range check and radius
// product, margin add, square, compare), one result per request, in order.
// The config channel is always ready; write it only with no request in
// flight. Depends on pic_pkg, pic_cfg, pic_front and pic_back.
module point_in_cone_test
    import pic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_pic_req             i_req,
    output logic                 o_done,
    output t_pic_res             o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    localparam int LATENCY = 7;

    t_pic_cfg            cfg;
    logic [HEIGHT_W-1:0] base_radius;
    logic                mid_vld;
    t_pic_mid            mid;
    logic                req_take;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign req_take    = start && !busy;

    pic_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (i_cfg_valid && o_cfg_ready),
        .i_idx         (i_cfg_index),
        .i_data        (i_cfg_data),
        .o_cfg         (cfg),
        .o_base_radius (base_radius)
    );

    pic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (req_take),
        .i_req   (i_req),
        .i_cfg   (cfg),
        .o_vld   (mid_vld),
        .o_mid   (mid)
    );

    pic_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (mid_vld),
        .i_mid         (mid),
        .i_cfg         (cfg),
        .i_base_radius (base_radius),
        .o_done        (o_done),
        .o_res         (o_result)
    );

`ifndef SYNTHESIS
    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |-> ##LATENCY o_done)
        else $error("request did not produce a result on time");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(req_take, LATENCY))
        else $error("result strobe without a matching request");

    a_reset_clears_done: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe just after reset");
`endif

endmodule

@@ sim/pic_check.sv @@
`timescale 1ns / 1ps
// Point-in-cone checker: tracks config writes, predicts each request's verdict
// and base radius, and compares against the result strobe. Depends on pic_pkg.
module pic_check
    import pic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_pic_req             i_req,
    input  logic                 i_done,
    input  t_pic_res             i_result,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    output int                   o_pending,
    output int                   o_fails
);

    localparam longint RADIUS_CAP = (longint'(1) << HEIGHT_W) - 1;

    t_pic_cfg cone_cfg;
    t_pic_res verdicts[$];
    int       n_fail = 0;

    // floor(len * sine / 2^UNIT_FRAC), clipped to the largest radius
    function automatic longint scaled_len(input longint len, input longint sine);
        longint p;
        p = (len * sine) >>> UNIT_FRAC;
        return (p > RADIUS_CAP) ? RADIUS_CAP : p;
    endfunction

    // Squares stay below 2^52 at these widths, so the longint arithmetic never overflows.
    function automatic t_pic_res cone_verdict(input t_pic_req r, input t_pic_cfg c);
        longint vx, vy, vz, ax, ay, az, nx, ny, nz, cos_o, mg;
        longint h_full, h_lim, h8, t, lhs, rhs, facing, sine, height;
        logic   hit;
        t_pic_res res;
        ax     = longint'($signed(c.axis_x));
        ay     = longint'($signed(c.axis_y));
        az     = longint'($signed(c.axis_z));
        sine   = longint'(c.sin_half_angle);
        height = longint'(c.cone_height);
        vx     = longint'($signed(r.point_x)) - longint'($signed(c.apex_x));
        vy     = longint'($signed(r.point_y)) - longint'($signed(c.apex_y));
        vz     = longint'($signed(r.point_z)) - longint'($signed(c.apex_z));
        mg     = longint'($signed(r.margin));
        nx     = longint'($signed(r.normal_x));
        ny     = longint'($signed(r.normal_y));
        nz     = longint'($signed(r.normal_z));
        cos_o  = longint'($signed(r.cos_open));
        h_full = ax * vx + ay * vy + az * vz;
        h_lim  = height * (longint'(1) << UNIT_FRAC);
        hit    = 1'b0;
        if (h_full >= 0 && h_full <= h_lim) begin
            h8  = h_full >>> UNIT_FRAC;
            t   = scaled_len(h8, sine) + mg;
            lhs = vx * vx + vy * vy + vz * vz;
            rhs = t * t + h8 * h8;
            hit = (lhs < rhs);
        end
        if (hit && r.check_face) begin
            facing = -(ax * nx + ay * ny + az * nz);
            hit    = (facing > cos_o * (longint'(1) << UNIT_FRAC));
        end
        res.inside_res  = hit;
        res.base_radius = HEIGHT_W'(scaled_len(height, sine));
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pic_res want;
        if (!i_rst_n) begin
            cone_cfg        = '0;
            cone_cfg.axis_y = UNIT_W'(1 << UNIT_FRAC);
            verdicts.delete();
        end else begin
            if (i_done) begin
                if (verdicts.size() == 0) begin
                    $error("o_result: result with no request outstanding");
                    n_fail++;
                end else begin
                    want = verdicts.pop_front();
                    if (i_result.inside_res !== want.inside_res) begin
                        $error("inside_res: expected %0d, got %0d",
                               want.inside_res, i_result.inside_res);
                        n_fail++;
                    end
                    if (i_result.base_radius !== want.base_radius) begin
                        $error("base_radius: expected %0d, got %0d",
                               want.base_radius, i_result.base_radius);
                        n_fail++;
                    end
                end
            end
            if (i_start && !i_busy)
                verdicts.push_back(cone_verdict(i_req, cone_cfg));
            // new register values apply to requests after this edge
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_APEX_X:         cone_cfg.apex_x = i_cfg_data;
                    CFG_APEX_Y:         cone_cfg.apex_y = i_cfg_data;
                    CFG_APEX_Z:         cone_cfg.apex_z = i_cfg_data;
                    CFG_AXIS_X:         cone_cfg.axis_x = i_cfg_data[UNIT_W-1:0];
                    CFG_AXIS_Y:         cone_cfg.axis_y = i_cfg_data[UNIT_W-1:0];
                    CFG_AXIS_Z:         cone_cfg.axis_z = i_cfg_data[UNIT_W-1:0];
                    CFG_CONE_HEIGHT:    cone_cfg.cone_height = i_cfg_data[HEIGHT_W-1:0];
                    CFG_SIN_HALF_ANGLE: cone_cfg.sin_half_angle = i_cfg_data[SIN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= verdicts.size();
        o_fails   <= n_fail;
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Point-in-cone testbench top: clock, reset, config and request stimulus,
// verdict. Depends on pic_pkg, pic_check and point_in_cone_test.
module tb;
    import pic_pkg::*;

    localparam int LATENCY = 7;
    localparam int LIMIT   = 200000;
    localparam int PER_SET = 60;

    typedef enum {CONE_TYPICAL, CONE_HUGE, CONE_CORNER, CONE_FLAT, CONE_WIDE} t_cone_kind;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    t_pic_req             i_req       = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0]   i_cfg_data  = '0;
    logic                 busy;
    logic                 o_done;
    t_pic_res             o_result;
    logic                 o_cfg_ready;
    int                   pending;
    int                   fails;
    int                   cycles      = 0;
    int                   burst_left  = 0;

    point_in_cone_test dut (
        .i_clk, .i_rst_n, .start, .busy, .i_req, .o_done, .o_result,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    pic_check cone_watch (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_req,
        .i_done(o_done), .i_result(o_result), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_fails(fails)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly back-to-back or short gaps, some long ones, plus idle-free bursts
    function automatic int idle_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [COORD_W-1:0] clip_coord(input longint v);
        if (v > 8388607)
            return COORD_W'(8388607);
        if (v < -8388608)
            return COORD_W'(-8388608);
        return COORD_W'(v);
    endfunction

    // random direction biased towards (bx, by, bz), scaled to Q1.14
    function automatic void unit_dir(input real bx, input real by, input real bz,
                                     output int x, output int y, output int z);
        real a, b, c, n;
        do begin
            a = bx + real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
            b = by + real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
            c = bz + real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
            n = $sqrt(a * a + b * b + c * c);
        end while (n < 0.01);
        x = $rtoi(a / n * 16384.0);
        y = $rtoi(b / n * 16384.0);
        z = $rtoi(c / n * 16384.0);
    endfunction

    function automatic t_pic_req plain_req(input int px, input int py, input int pz,
                                           input int mg);
        t_pic_req r;
        r        = '0;
        r.point_x = COORD_W'(px);
        r.point_y = COORD_W'(py);
        r.point_z = COORD_W'(pz);
        r.margin  = COORD_W'(mg);
        return r;
    endfunction

    function automatic t_pic_req faced(input t_pic_req base, input logic on,
                                       input int nx, input int ny, input int nz,
                                       input int co);
        t_pic_req r;
        r            = base;
        r.check_face = on;
        r.normal_x   = UNIT_W'(nx);
        r.normal_y   = UNIT_W'(ny);
        r.normal_z   = UNIT_W'(nz);
        r.cos_open   = UNIT_W'(co);
        return r;
    endfunction

    function automatic t_pic_req noise_req();
        t_pic_req r;
        r.point_x    = COORD_W'($urandom());
        r.point_y    = COORD_W'($urandom());
        r.point_z    = COORD_W'($urandom());
        r.margin     = COORD_W'($urandom());
        r.check_face = 1'($urandom_range(0, 1));
        r.normal_x   = UNIT_W'(int'($urandom_range(0, 32768)) - 16384);
        r.normal_y   = UNIT_W'(int'($urandom_range(0, 32768)) - 16384);
        r.normal_z   = UNIT_W'(int'($urandom_range(0, 32768)) - 16384);
        r.cos_open   = UNIT_W'(int'($urandom_range(0, 32768)) - 16384);
        return r;
    endfunction

    // point scattered around the cone surface so both verdicts are common
    function automatic t_pic_req shaped_req(input t_pic_cfg c);
        t_pic_req r;
        real ax, ay, az, hh, rr;
        int  ux, uy, uz, nx, ny, nz;
        ax = real'(int'($signed(c.axis_x))) / 16384.0;
        ay = real'(int'($signed(c.axis_y))) / 16384.0;
        az = real'(int'($signed(c.axis_z))) / 16384.0;
        hh = real'(c.cone_height) * (real'($urandom_range(0, 1200)) / 1000.0 - 0.1);
        rr = hh * real'(c.sin_half_angle) / 16384.0
             * real'($urandom_range(0, 1500)) / 1000.0;
        if (rr < 0.0)
            rr = -rr;
        rr = rr + real'($urandom_range(0, 64));
        unit_dir(0.0, 0.0, 0.0, ux, uy, uz);
        r.point_x = clip_coord(longint'($signed(c.apex_x))
                               + $rtoi(ax * hh + real'(ux) / 16384.0 * rr));
        r.point_y = clip_coord(longint'($signed(c.apex_y))
                               + $rtoi(ay * hh + real'(uy) / 16384.0 * rr));
        r.point_z = clip_coord(longint'($signed(c.apex_z))
                               + $rtoi(az * hh + real'(uz) / 16384.0 * rr));
        if ($urandom_range(0, 9) < 7)
            r.margin = COORD_W'(int'($urandom_range(0, 512)) - 256);
        else
            r.margin = COORD_W'($urandom());
        r.check_face = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
            unit_dir(0.0, 0.0, 0.0, nx, ny, nz);
        else
            unit_dir(-1.5 * ax, -1.5 * ay, -1.5 * az, nx, ny, nz);
        r.normal_x = UNIT_W'(nx);
        r.normal_y = UNIT_W'(ny);
        r.normal_z = UNIT_W'(nz);
        r.cos_open = UNIT_W'(int'($urandom_range(0, 32768)) - 16384);
        return r;
    endfunction

    function automatic t_pic_cfg rand_cfg(input t_cone_kind kind);
        t_pic_cfg c;
        int       x, y, z;
        unit_dir(0.0, 0.0, 0.0, x, y, z);
        c.apex_x         = COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        c.apex_y         = COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        c.apex_z         = COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        c.axis_x         = UNIT_W'(x);
        c.axis_y         = UNIT_W'(y);
        c.axis_z         = UNIT_W'(z);
        c.cone_height    = HEIGHT_W'($urandom_range(0, 1 << 18));
        c.sin_half_angle = SIN_W'($urandom_range(0, 16384));
        case (kind)
            CONE_HUGE: begin
                c.apex_x         = COORD_W'(8388607);
                c.apex_y         = COORD_W'(-8388608);
                c.apex_z         = COORD_W'(0);
                c.cone_height    = HEIGHT_W'(8388607);
                c.sin_half_angle = SIN_W'(16384);
            end
            CONE_CORNER: begin
                // axis not of unit length, sine past one: radius saturates
                c.apex_x         = COORD_W'(-8388608);
                c.apex_y         = COORD_W'(8388607);
                c.apex_z         = COORD_W'(-8388608);
                c.axis_x         = UNIT_W'(16384);
                c.axis_y         = UNIT_W'(16384);
                c.axis_z         = UNIT_W'(-16384);
                c.cone_height    = HEIGHT_W'(8388607);
                c.sin_half_angle = SIN_W'(32767);
            end
            CONE_FLAT: begin
                c.cone_height    = '0;
                c.sin_half_angle = '0;
            end
            CONE_WIDE: begin
                c.cone_height    = HEIGHT_W'($urandom_range(0, 1 << 16));
                c.sin_half_angle = SIN_W'($urandom_range(16385, 32767));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic issue(input t_pic_req r);
        int gap;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [COORD_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        if ($urandom_range(0, 3) == 0) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // narrow registers get random junk in the unused upper data bits
    task automatic cone_setup(input t_pic_cfg c);
        logic [COORD_W-1:0] d;
        cfg_write(CFG_APEX_X, c.apex_x);
        cfg_write(CFG_APEX_Y, c.apex_y);
        cfg_write(CFG_APEX_Z, c.apex_z);
        d = COORD_W'($urandom());
        d[UNIT_W-1:0] = c.axis_x;
        cfg_write(CFG_AXIS_X, d);
        d = COORD_W'($urandom());
        d[UNIT_W-1:0] = c.axis_y;
        cfg_write(CFG_AXIS_Y, d);
        d = COORD_W'($urandom());
        d[UNIT_W-1:0] = c.axis_z;
        cfg_write(CFG_AXIS_Z, d);
        d = COORD_W'($urandom());
        d[HEIGHT_W-1:0] = c.cone_height;
        cfg_write(CFG_CONE_HEIGHT, d);
        d = COORD_W'($urandom());
        d[SIN_W-1:0] = c.sin_half_angle;
        cfg_write(CFG_SIN_HALF_ANGLE, d);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every outstanding request to come back, then let the pipe empty
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    initial begin
        t_pic_cfg   c;
        t_pic_req   mid;
        t_cone_kind plan[10];
        plan = '{CONE_TYPICAL, CONE_HUGE, CONE_TYPICAL, CONE_FLAT, CONE_TYPICAL,
                 CONE_CORNER, CONE_TYPICAL, CONE_WIDE, CONE_TYPICAL, CONE_TYPICAL};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero-height cone along +y at the origin
        issue(plain_req(0, 0, 0, 1));
        issue(plain_req(5, 0, 0, 10));
        issue(plain_req(0, 1, 0, 100));
        issue(plain_req(0, -1, 0, 100));
        settle();

        // 25600-unit cone along +y, 30 degree half angle
        c                = '0;
        c.apex_x         = COORD_W'(1000);
        c.apex_y         = COORD_W'(-2000);
        c.apex_z         = COORD_W'(300);
        c.axis_y         = UNIT_W'(16384);
        c.cone_height    = HEIGHT_W'(25600);
        c.sin_half_angle = SIN_W'(8192);
        cone_setup(c);
        issue(plain_req(1000, -2000, 300, 0));       // at the apex, no margin
        issue(plain_req(1000, -2000, 300, 1));
        issue(plain_req(1000, 23600, 300, 0));       // exactly at full height
        issue(plain_req(1000, 23601, 300, 0));       // just past the base
        issue(plain_req(1000, -2001, 300, 0));       // behind the apex
        issue(plain_req(7399, 10800, 300, 0));       // just inside the wall
        issue(plain_req(7400, 10800, 300, 0));       // on the wall
        issue(plain_req(101000, 10800, 300, -8388608)); // negative total radius
        issue(plain_req(101000, 10800, 300, 8388607));
        issue(plain_req(-8388608, -8388608, -8388608, 8388607));
        issue(plain_req(8388607, 8388607, 8388607, -8388608));
        mid = plain_req(1000, 10800, 300, 0);
        issue(faced(mid, 1'b1, 0, -16384, 0, 0));
        issue(faced(mid, 1'b1, 0, -16384, 0, 16384));
        issue(faced(mid, 1'b1, 0, 16384, 0, -16384));
        issue(faced(mid, 1'b1, 16384, -16384, -16384, -16384));
        issue(faced(mid, 1'b0, 0, 16384, 0, 16384)); // facing test off
        settle();

        foreach (plan[p]) begin
            c = rand_cfg(plan[p]);
            cone_setup(c);
            repeat (PER_SET) begin
                if ($urandom_range(0, 4) == 0)
                    issue(noise_req());
                else
                    issue(shaped_req(c));
            end
            settle();
        end

        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pic_pkg.sv
rtl/core/pic_cfg.sv
rtl/core/pic_front.sv
rtl/core/pic_back.sv
rtl/core/point_in_cone_test.sv
sim/pic_check.sv
sim/tb.sv
